>>> hdl/crtt_pkg.sv
package crtt_pkg;

  // Fixed field widths of the beat payloads.
  localparam int unsigned AddrW      = 64;
  localparam int unsigned SizeW      = 16;
  localparam int unsigned KindW      = 3;
  localparam int unsigned DepthOutW  = 7;

  // Default number of shadow stack cells.
  localparam int unsigned StackDepthDef = 64;

  // Transition classes reported for every block.
  typedef enum logic [KindW-1:0] {
    KIND_START = 3'd0,
    KIND_SEQ   = 3'd1,
    KIND_CALL  = 3'd2,
    KIND_RET   = 3'd3,
    KIND_JUMP  = 3'd4
  } kind_e;

  // Sequencer states of the top level.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_e;

  // Control broadcast from the sequencer to every stack cell.
  typedef struct packed {
    logic              capture;
    logic              push;
    logic [AddrW-1:0]  pc;
    logic [AddrW-1:0]  push_ret;
    logic [AddrW-1:0]  push_caller;
  } cell_ctrl_t;

  // Data handed from one cell to the next lower cell.
  typedef struct packed {
    logic              found;
    logic [AddrW-1:0]  caller;
  } cell_chain_t;

endpackage

>>> hdl/crtt_cell.sv
module crtt_cell #(
  parameter int unsigned STACK_DEPTH = crtt_pkg::StackDepthDef,
  parameter int unsigned IDX         = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  crtt_pkg::cell_ctrl_t                ctrl_i,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]    count_i,
  input  crtt_pkg::cell_chain_t               chain_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]      idx_i,
  output crtt_pkg::cell_chain_t               chain_o,
  output logic [$clog2(STACK_DEPTH)-1:0]      idx_o
);
  import crtt_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  logic [AddrW-1:0] ret_q;
  logic [AddrW-1:0] caller_q;
  logic             hit_q;
  logic             hit_d;
  logic             live;
  logic             sel;

  // The cell holds a live entry while its slot lies below the stack count.
  assign live = CntW'(IDX) < count_i;

  // Entry storage: written by a push aimed at this slot.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (count_i == CntW'(IDX))) begin
      ret_q    <= ctrl_i.push_ret;
      caller_q <= ctrl_i.push_caller;
    end
  end

  // Return-address compare, registered when a beat is captured.
  assign hit_d = live && (ret_q == ctrl_i.pc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      hit_q <= hit_d;
    end
  end

  // Only the topmost hitting cell places its caller and slot on the chain.
  assign sel            = hit_q && !chain_i.found;
  assign chain_o.found  = chain_i.found || hit_q;
  assign chain_o.caller = chain_i.caller | (sel ? caller_q : '0);
  assign idx_o          = idx_i | (sel ? IdxW'(IDX) : '0);

endmodule

>>> hdl/call_return_transition_tracker.sv
// Call/return transition tracker with a shadow call stack. Each input beat
// describes one executed basic block; the block classifies it as start,
// sequential, call, return or jump and returns one result beat carrying the
// class, the active caller address, the stack depth and an overflow flag.
// The stack is a row of STACK_DEPTH cells, each holding one (return address,
// caller address) entry and comparing it against the new block address.
// The cells compare and register their hits in the accept cycle. In the
// evaluate state, which waits while an earlier result is not yet taken,
// the hit chain resolves the topmost match, state is updated and the
// result is loaded into the output register. A new beat is taken while a
// result still waits. A push onto a full stack is dropped and flagged.
module call_return_transition_tracker #(
  parameter int unsigned STACK_DEPTH = crtt_pkg::StackDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [crtt_pkg::AddrW-1:0]      block_pc_i,
  input  logic [crtt_pkg::SizeW-1:0]      block_size_i,
  input  logic                            is_symbol_entry_i,
  input  logic [crtt_pkg::AddrW-1:0]      callee_return_address_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [crtt_pkg::KindW-1:0]      transition_kind_o,
  output logic [crtt_pkg::AddrW-1:0]      caller_pc_o,
  output logic [crtt_pkg::DepthOutW-1:0]  stack_depth_o,
  output logic                            overflow_o
);
  import crtt_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  state_e state_q, state_d;

  // Architectural state.
  logic             seen_q, seen_d;
  logic [AddrW-1:0] prev_end_q, prev_end_d;
  logic [AddrW-1:0] prev_pc_q, prev_pc_d;
  logic [AddrW-1:0] active_q, active_d;
  logic [CntW-1:0]  count_q, count_d;

  // Captured beat.
  logic [AddrW-1:0] pc_q;
  logic [SizeW-1:0] size_q;
  logic             entry_q;
  logic             seq_q;
  logic             saved_q;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  kind_e                kind_q, kind_d;
  logic [AddrW-1:0]     caller_out_q;
  logic [DepthOutW-1:0] depth_q, depth_d;
  logic                 ovf_q, ovf_d;

  logic        accept;
  logic        finish;
  logic        do_push;
  logic        full;
  logic [CntW+DepthOutW-1:0] depth_ext;

  cell_ctrl_t  ctrl;
  cell_chain_t chain [STACK_DEPTH+1];
  logic [IdxW-1:0] idx_chain [STACK_DEPTH+1];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(STACK_DEPTH));

  // Cell row: the chain runs from the top slot down to slot zero.
  assign chain[STACK_DEPTH]     = '0;
  assign idx_chain[STACK_DEPTH] = '0;

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    crtt_cell #(
      .STACK_DEPTH(STACK_DEPTH),
      .IDX        (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .count_i(count_q),
      .chain_i(chain[g+1]),
      .idx_i  (idx_chain[g+1]),
      .chain_o(chain[g]),
      .idx_o  (idx_chain[g])
    );
  end

  // Capture the beat together with the two address compares.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pc_q    <= block_pc_i;
      size_q  <= block_size_i;
      entry_q <= is_symbol_entry_i;
      seq_q   <= (block_pc_i == prev_end_q);
      saved_q <= (callee_return_address_i == prev_end_q);
    end
  end

  // Sequencer, classification and next state.
  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    prev_end_d  = prev_end_q;
    prev_pc_d   = prev_pc_q;
    active_d    = active_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    depth_d     = depth_q;
    ovf_d       = ovf_q;
    finish      = 1'b0;
    do_push     = 1'b0;
    depth_ext   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!out_valid_q || out_ready_i) begin
          finish = 1'b1;
          if (!seen_q) begin
            kind_d = KIND_START;
          end else if (seq_q) begin
            kind_d = KIND_SEQ;
          end else if (entry_q) begin
            kind_d  = KIND_CALL;
            do_push = 1'b1;
          end else if (chain[0].found) begin
            kind_d   = KIND_RET;
            active_d = chain[0].caller;
            count_d  = CntW'(idx_chain[0]);
          end else if (saved_q) begin
            kind_d  = KIND_CALL;
            do_push = 1'b1;
          end else begin
            kind_d = KIND_JUMP;
          end

          if (do_push) begin
            active_d = prev_pc_q;
            if (!full) begin
              count_d = count_q + CntW'(1);
            end
          end
          ovf_d = do_push && full;

          seen_d      = 1'b1;
          prev_pc_d   = pc_q;
          prev_end_d  = pc_q + AddrW'(size_q);
          depth_ext   = (CntW+DepthOutW)'(count_d);
          depth_d     = depth_ext[DepthOutW-1:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Broadcast to the cells: compare on capture, write on a push.
  assign ctrl.capture     = accept;
  assign ctrl.push        = do_push && !full;
  assign ctrl.pc          = block_pc_i;
  assign ctrl.push_ret    = prev_end_q;
  assign ctrl.push_caller = prev_pc_q;

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seen_q      <= 1'b0;
      prev_end_q  <= '0;
      prev_pc_q   <= '0;
      active_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      prev_end_q  <= prev_end_d;
      prev_pc_q   <= prev_pc_d;
      active_q    <= active_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded when an item finishes.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      kind_q       <= kind_d;
      caller_out_q <= active_d;
      depth_q      <= depth_d;
      ovf_q        <= ovf_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign transition_kind_o = kind_q;
  assign caller_pc_o       = caller_out_q;
  assign stack_depth_o     = depth_q;
  assign overflow_o        = ovf_q;

endmodule
